@@ rtl/dual_header_frame_receiver_macros.svh @@
// Assertion macros shared by the checker files of the dual-header frame receiver.
// Needs nothing else; every macro takes its clock and active-low reset as arguments.
`ifndef DUAL_HEADER_FRAME_RECEIVER_MACROS_SVH
`define DUAL_HEADER_FRAME_RECEIVER_MACROS_SVH

// General property check, disabled while reset is asserted.
`define DHFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A stalled transaction keeps the given signal unchanged in the next cycle.
`define DHFR_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

@@ rtl/dhfr_pkg.sv @@
// Package for the dual-header frame receiver: header codes, hunt phases and the
// queue entry passed from the front part to the back part. No dependencies.
package dhfr_pkg;

  localparam logic [7:0] HdrAaByte0 = 8'hAA;
  localparam logic [7:0] HdrAaByte1 = 8'h55;
  localparam logic [7:0] HdrCcByte0 = 8'hCC;
  localparam logic [7:0] HdrCcByte1 = 8'h66;
  localparam logic [7:0] MinLength  = 8'd5;
  localparam logic [7:0] BadLength  = 8'd255;
  localparam logic [7:0] StartPos   = 8'd2;
  localparam logic [7:0] FirstBody  = 8'd3;

  // Modulo-256 sums of the two header bytes, seeding the running checksum.
  localparam logic [7:0] HdrAaSum = 8'(HdrAaByte0 + HdrAaByte1);
  localparam logic [7:0] HdrCcSum = 8'(HdrCcByte0 + HdrCcByte1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SAW_AA,
    PH_SAW_CC,
    PH_LENGTH,
    PH_BODY
  } phase_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_BODY  = 1'b1
  } item_kind_e;

  typedef enum logic {
    HDR_AA55 = 1'b0,
    HDR_CC66 = 1'b1
  } hdr_kind_e;

  typedef struct packed {
    item_kind_e kind;
    hdr_kind_e  hdr;
    logic [7:0] data;
    logic [7:0] pos;
    logic       last;
  } entry_t;

endpackage

@@ rtl/dhfr_front.sv @@
// Front part of the dual-header frame receiver: header hunt, length check and
// byte positions. Depends on dhfr_pkg; feeds dhfr_queue.
module dhfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            full_i,
  output logic            push_o,
  output dhfr_pkg::entry_t push_entry_o
);
  import dhfr_pkg::*;

  phase_e     phase_q, phase_d;
  hdr_kind_e  hdr_q, hdr_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic       accept;
  logic       is_last;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_last    = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hdr_q   <= HDR_AA55;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    hdr_d        = hdr_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    push_o       = 1'b0;
    push_entry_o = '{kind: KIND_BODY, hdr: hdr_q, data: in_byte_i, pos: cnt_q, last: 1'b0};
    if (accept) begin
      unique case (phase_q)
        PH_SAW_AA: begin
          if (in_byte_i == HdrAaByte1) begin
            hdr_d   = HDR_AA55;
            phase_d = PH_LENGTH;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_SAW_CC: begin
          if (in_byte_i == HdrCcByte1) begin
            hdr_d   = HDR_CC66;
            phase_d = PH_LENGTH;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_LENGTH: begin
          if (in_byte_i < MinLength) begin
            phase_d = PH_IDLE;
          end else begin
            len_d             = in_byte_i;
            cnt_d             = FirstBody;
            phase_d           = PH_BODY;
            push_o            = 1'b1;
            push_entry_o.kind = KIND_START;
            push_entry_o.pos  = StartPos;
          end
        end
        PH_BODY: begin
          push_o = 1'b1;
          if (is_last) begin
            push_entry_o.last = 1'b1;
            phase_d           = PH_IDLE;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end
        default: begin
          if (in_byte_i == HdrAaByte0) begin
            phase_d = PH_SAW_AA;
          end else if (in_byte_i == HdrCcByte0) begin
            phase_d = PH_SAW_CC;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/dhfr_queue.sv @@
// Two-entry queue between the front and back parts of the frame receiver.
// Depends on dhfr_pkg for the entry type.
module dhfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dhfr_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dhfr_pkg::entry_t pop_entry_o
);
  import dhfr_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o      = count_q[1];
  assign valid_o     = count_q != 2'd0;
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ rtl/dhfr_back.sv @@
// Back part of the frame receiver: running checksum, end-of-frame verdict and
// the output register. Depends on dhfr_pkg; drains dhfr_queue.
module dhfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dhfr_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dhfr_pkg::entry_t out_entry_o,
  output logic             out_ok_o
);
  import dhfr_pkg::*;

  logic [7:0] sum_q, sum_d;
  logic       len_bad_q, len_bad_d;
  logic       out_valid_q;
  entry_t     out_entry_q;
  logic       out_ok_q, ok_d;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_entry_o = out_entry_q;
  assign out_ok_o    = out_ok_q;

  always_comb begin
    sum_d     = sum_q;
    len_bad_d = len_bad_q;
    ok_d      = 1'b0;
    unique case (entry_i.kind)
      KIND_START: begin
        sum_d     = ((entry_i.hdr == HDR_CC66) ? HdrCcSum : HdrAaSum) + entry_i.data;
        len_bad_d = entry_i.data == BadLength;
      end
      KIND_BODY: begin
        if (entry_i.last) begin
          ok_d = (sum_q == entry_i.data) && !len_bad_q;
        end else begin
          sum_d = sum_q + entry_i.data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      len_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        sum_q       <= sum_d;
        len_bad_q   <= len_bad_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_entry_q <= entry_i;
      out_ok_q    <= ok_d;
    end
  end

endmodule

@@ rtl/dual_header_frame_receiver.sv @@
// Top level of the dual-header frame receiver.
// Depends on dhfr_pkg, dhfr_front, dhfr_queue and dhfr_back.
//
// Usage: the slave stream carries one received serial byte per transaction.
// The block hunts for a header of AA 55 or CC 66, then reads a length byte
// that counts the whole frame including header and checksum. A valid length
// (5 or more) yields a frame-start transaction on the master stream with the
// length in the value field and position 2. Every later byte of the frame
// yields a body transaction carrying the byte and its position; the final
// byte is marked with tlast and frame_ok tells whether the 8-bit sum of
// header, length and payload matches it (a length of 255 never passes).
// Header bytes, broken headers and short lengths produce no output.
// An accepted byte goes from the front classifier into the two-entry queue,
// then through the checksum stage into the output register. Throughput is
// one byte per cycle, limited only by the queue: the slave side is ready
// whenever the queue has room, so a stalled master stream fills the queue
// and output register (three results) and then back-pressures the slave side.
// Reset clears the hunt state, the queue and the output valid; the block
// is ready as soon as reset is released.
module dual_header_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] value, [15:8] position, [16] frame_ok
  output logic [1:0]  m_axis_tuser_o,   // [0] item_kind, [1] header_kind
  output logic        m_axis_tlast_o    // last
);
  import dhfr_pkg::*;

  logic   push, full, pop, q_valid, out_ok;
  entry_t push_entry, pop_entry, out_entry;

  // Classifies each received byte and decides whether it produces a result.
  dhfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decouples the classifier from output back-pressure.
  dhfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  // Keeps the checksum and holds the result until the master side takes it.
  dhfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_entry_o (out_entry),
    .out_ok_o    (out_ok)
  );

  assign m_axis_tdata_o = {7'd0, out_ok, out_entry.pos, out_entry.data};
  assign m_axis_tuser_o = {out_entry.hdr, out_entry.kind};
  assign m_axis_tlast_o = out_entry.last;

endmodule

@@ rtl/dhfr_checker.sv @@
// Port-level checker for the dual-header frame receiver and its bind statement.
// Depends on dual_header_frame_receiver_macros.svh.
module dhfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  `include "dual_header_frame_receiver_macros.svh"

  // A stalled output transaction keeps its payload.
  `DHFR_ASSERT_HOLD(a_hold_data, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o, "output data changed while stalled")

  // A pass verdict only ever appears on the final byte of a frame.
  `DHFR_ASSERT(a_ok_on_last, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tdata_o[16]) |-> m_axis_tlast_o, "frame_ok outside the last byte")

  // A frame-start transaction sits at position 2, is never last and has a length of at least 5.
  `DHFR_ASSERT(a_start_shape, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[15:8] == 8'd2 && !m_axis_tlast_o && m_axis_tdata_o[7:0] >= 8'd5), "malformed frame-start transaction")

  // Body bytes always sit past the length byte.
  `DHFR_ASSERT(a_body_pos, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[15:8] >= 8'd3), "body byte at header position")

endmodule

bind dual_header_frame_receiver dhfr_checker u_dhfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

@@ tb/sv/tb_dual_header_frame_receiver.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the dual-header frame receiver top level.
// Depends on dhfr_pkg for phase, kind and header constants; drives both streams
// with random stalls and checks every output transaction against a local model.
module tb_dual_header_frame_receiver;
  import dhfr_pkg::*;

  localparam int unsigned RunLimit   = 400000;
  localparam int unsigned DrainLimit = 5000;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned RandomStop = 1400;
  localparam int unsigned TotalStop  = 1550;

  typedef struct packed {
    item_kind_e kind;
    hdr_kind_e  hdr;
    logic [7:0] value;
    logic [7:0] pos;
    logic       last;
    logic       ok;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Model of the frame hunter.
  phase_e     hunt_phase = PH_IDLE;
  hdr_kind_e  frame_hdr = HDR_AA55;
  logic [7:0] frame_len = 8'd0;
  logic [7:0] next_pos = 8'd0;
  logic [7:0] frame_sum = 8'd0;

  rx_item_t    items_due[$];
  rx_item_t    item_want;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  int unsigned sink_stall_left = 0;

  dual_header_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Advances the frame model by one accepted byte and queues the item it yields.
  task automatic track_rx_byte(input logic [7:0] b);
    rx_item_t item;
    item = '0;
    item.hdr = frame_hdr;
    case (hunt_phase)
      PH_SAW_AA: begin
        if (b == HdrAaByte1) begin
          frame_hdr  = HDR_AA55;
          hunt_phase = PH_LENGTH;
        end else begin
          hunt_phase = PH_IDLE;
        end
      end
      PH_SAW_CC: begin
        if (b == HdrCcByte1) begin
          frame_hdr  = HDR_CC66;
          hunt_phase = PH_LENGTH;
        end else begin
          hunt_phase = PH_IDLE;
        end
      end
      PH_LENGTH: begin
        if (b < MinLength) begin
          hunt_phase = PH_IDLE;
        end else begin
          frame_len = b;
          next_pos  = FirstBody;
          if (frame_hdr == HDR_CC66) begin
            frame_sum = 8'(HdrCcByte0 + HdrCcByte1 + b);
          end else begin
            frame_sum = 8'(HdrAaByte0 + HdrAaByte1 + b);
          end
          hunt_phase = PH_BODY;
          item.kind  = KIND_START;
          item.value = b;
          item.pos   = StartPos;
          items_due.push_back(item);
        end
      end
      PH_BODY: begin
        item.kind  = KIND_BODY;
        item.value = b;
        item.pos   = next_pos;
        if ({1'b0, next_pos} + 9'd1 >= {1'b0, frame_len}) begin
          // Checksum byte: closes the frame whatever its value.
          item.last  = 1'b1;
          item.ok    = (frame_sum == b) && (frame_len != BadLength);
          hunt_phase = PH_IDLE;
        end else begin
          frame_sum = frame_sum + b;
          next_pos  = next_pos + 8'd1;
        end
        items_due.push_back(item);
      end
      default: begin
        if (b == HdrAaByte0) begin
          hunt_phase = PH_SAW_AA;
        end else if (b == HdrCcByte0) begin
          hunt_phase = PH_SAW_CC;
        end else begin
          hunt_phase = PH_IDLE;
        end
      end
    endcase
  endtask

  // Presents one byte on the slave stream, optionally after a gap, and waits for
  // the transaction to complete. Called right after a rising edge.
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  // Sends header, length, random payload and checksum. Lengths under the minimum
  // stop after the length byte, since the receiver drops the frame there.
  task automatic send_frame(input bit use_cc, input logic [7:0] len, input bit good_sum);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] sum;
    logic [7:0] pay;
    b0 = use_cc ? HdrCcByte0 : HdrAaByte0;
    b1 = use_cc ? HdrCcByte1 : HdrAaByte1;
    send_byte(b0);
    send_byte(b1);
    send_byte(len);
    if (len >= MinLength) begin
      sum = 8'(b0 + b1 + len);
      for (int unsigned i = 0; i < len - 4; i++) begin
        pay = 8'($urandom_range(0, 255));
        send_byte(pay);
        sum = sum + pay;
      end
      send_byte(good_sum ? sum : 8'(sum + $urandom_range(1, 255)));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic wait_items_drained();
    int unsigned guard;
    guard = 0;
    while (items_due.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Output stream consumer with random stall bursts.
  always @(posedge clk_i) begin
    if (sink_idle_en && sink_stall_left == 0 && $urandom_range(0, 7) == 0) begin
      sink_stall_left <= $urandom_range(1, 12);
      m_axis_tready_i <= 1'b0;
    end else if (sink_stall_left != 0) begin
      sink_stall_left <= sink_stall_left - 1;
      m_axis_tready_i <= (sink_stall_left == 1);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Checks each output transaction against the oldest expected item.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (items_due.size() == 0) begin
        report_mismatch("item with none expected, value", m_axis_tdata_o[7:0], 8'h00);
      end else begin
        item_want = items_due.pop_front();
        if (m_axis_tuser_o[0] !== item_want.kind)
          report_mismatch("item_kind", 8'(m_axis_tuser_o[0]), 8'(item_want.kind));
        if (m_axis_tuser_o[1] !== item_want.hdr)
          report_mismatch("header_kind", 8'(m_axis_tuser_o[1]), 8'(item_want.hdr));
        if (m_axis_tdata_o[7:0] !== item_want.value)
          report_mismatch("value", m_axis_tdata_o[7:0], item_want.value);
        if (m_axis_tdata_o[15:8] !== item_want.pos)
          report_mismatch("position", m_axis_tdata_o[15:8], item_want.pos);
        if (m_axis_tlast_o !== item_want.last)
          report_mismatch("last", 8'(m_axis_tlast_o), 8'(item_want.last));
        if (m_axis_tdata_o[16] !== item_want.ok)
          report_mismatch("frame_ok", 8'(m_axis_tdata_o[16]), 8'(item_want.ok));
      end
    end
  end

  // Broken and repeated headers, short lengths, the shortest frame, both header
  // kinds and both checksum outcomes.
  task automatic test_directed();
    send_byte(HdrAaByte0);
    send_byte(8'h00);
    send_byte(HdrAaByte0);
    send_byte(HdrAaByte0);
    send_byte(HdrAaByte1);
    send_byte(HdrCcByte0);
    send_byte(8'hFF);
    send_frame(1'b0, 8'd4, 1'b1);
    send_frame(1'b1, 8'd0, 1'b1);
    send_frame(1'b0, MinLength, 1'b1);
    send_frame(1'b1, 8'd6, 1'b0);
  endtask

  // The longest frames: the one whose length always fails and the one below it.
  task automatic test_long_frames();
    send_frame(1'b1, BadLength, 1'b1);
    send_frame(1'b0, 8'd254, 1'b1);
  endtask

  // The sender holds off until the receiver has delivered everything.
  task automatic test_drain_pause();
    send_frame(1'b0, 8'd7, 1'b1);
    send_frame(1'b1, 8'd9, 1'b0);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait_items_drained();
    send_frame(1'b1, 8'd5, 1'b1);
  endtask

  // Mostly well-formed frames with random content, mixed with noise bytes,
  // broken headers and short lengths; test_random_traffic switches idling per chunk.
  task automatic send_random_mix();
    int unsigned pick;
    logic [7:0]  len;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      if ($urandom_range(0, 7) == 0) len = 8'($urandom_range(21, 64));
      else len = 8'($urandom_range(5, 20));
      send_frame(1'($urandom_range(0, 1)), len, 1'($urandom_range(0, 1)));
    end else if (pick < 16) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 18) begin
      send_byte($urandom_range(0, 1) ? HdrAaByte0 : HdrCcByte0);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_frame(1'($urandom_range(0, 1)), 8'($urandom_range(0, 4)), 1'b1);
    end
  endtask

  task automatic test_random_traffic();
    while (bytes_sent < RandomStop) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      repeat (4) send_random_mix();
    end
  endtask

  task automatic test_full_rate();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    while (bytes_sent < TotalStop) send_random_mix();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_frames();
    test_drain_pause();
    test_random_traffic();
    test_full_rate();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    wait_items_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (items_due.size() != 0) begin
      report_mismatch("items never delivered, count", 8'(items_due.size()), 8'h00);
    end
    if (mismatch_count == 0) begin
      $display("tb_dual_header_frame_receiver passed");
    end else begin
      $display("tb_dual_header_frame_receiver failed");
    end
    $finish;
  end

  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("tb_dual_header_frame_receiver failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dhfr_pkg.sv
rtl/dhfr_front.sv
rtl/dhfr_queue.sv
rtl/dhfr_back.sv
rtl/dual_header_frame_receiver.sv
rtl/dhfr_checker.sv
tb/sv/tb_dual_header_frame_receiver.sv
